// ===== design/skt_pkg.sv =====
// Shared types and constants of the sorted key table.
package skt_pkg;

    localparam int ENTRIES_DEF      = 64;
    localparam int PAYLOAD_BITS_DEF = 32;

    localparam int KEY_W     = 64;
    localparam int PORT_W    = 16;
    localparam int IN_PAY_W  = 32;
    localparam int POS_W     = 7;
    localparam int STATUS_W  = 2;
    localparam int S_DATA_W  = 112;
    localparam int M_DATA_W  = 16;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_UPDATED  = 2'd1,
        ST_ZERO_KEY = 2'd2,
        ST_FULL     = 2'd3
    } skt_status_t;

    // Controls broadcast to every cell of the chain.
    typedef struct packed {
        logic flag_en;   // capture the compare flags against the held item
        logic insert;    // shift right of the insertion point, place the item
        logic update;    // overwrite the payload of the matching cell
    } skt_cell_ctrl_t;

endpackage

// ===== design/sorted_key_table_upsert.sv =====
// Top level of the sorted key table with insert-or-update.
//
//  Channel | Direction | Handshake         | Payload
//  s_      | in        | s_tvalid/s_tready | s_tdata: key_id, port_number, payload
//  m_      | out       | m_tvalid/m_tready | m_tdata: status, position, entry_count
//
// An item is captured in S_IDLE; in S_CMP every cell of the chain compares
// its stored key with the item's key; in S_COMMIT the chain shifts and
// places the item (or overwrites a payload) and the result is registered.
// Reset clears the fill count, the state machine and the result valid; the
// entry storage is left as it is. A stalled result holds the table in
// S_COMMIT until the result register frees.
module sorted_key_table_upsert #(
    parameter int ENTRIES      = skt_pkg::ENTRIES_DEF,
    parameter int PAYLOAD_BITS = skt_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [63:0] key_id, [79:64] port_number, [111:80] payload
    input  logic [skt_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [1:0] status, [8:2] position, [15:9] entry_count
    output logic [skt_pkg::M_DATA_W-1:0]  m_tdata
);
    import skt_pkg::*;

    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE    = 3'b001,
        S_CMP     = 3'b010,
        S_COMMIT  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Item held for the whole operation.
    logic [KEY_W-1:0]        key_reg;
    logic [PORT_W-1:0]       port_reg;
    logic [PAYLOAD_BITS-1:0] payload_reg;

    logic [CW-1:0]           count_reg, count_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]     m_tdata_reg, m_tdata_next;

    logic [KEY_W-1:0]        cell_key     [ENTRIES];
    logic [PORT_W-1:0]       cell_port    [ENTRIES];
    logic [PAYLOAD_BITS-1:0] cell_payload [ENTRIES];
    logic [ENTRIES-1:0]      lt_vec;
    logic [ENTRIES-1:0]      eq_vec;

    skt_cell_ctrl_t          cell_ctrl;
    logic [CW-1:0]           position;
    logic                    hit;
    logic                    commit;
    logic                    zero_key;
    logic                    full;
    skt_status_t             status;
    logic [POS_W-1:0]        pos_out;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The result register must be free (or freeing) before the table changes.
    assign commit   = (state_reg == S_COMMIT) && (!m_tvalid_reg || m_tready);
    assign zero_key = (key_reg == '0);
    assign full     = (count_reg == CW'(ENTRIES));

    always_comb begin
        if (zero_key) begin
            status = ST_ZERO_KEY;
        end else if (hit) begin
            status = ST_UPDATED;
        end else if (full) begin
            status = ST_FULL;
        end else begin
            status = ST_INSERTED;
        end
    end

    always_comb begin
        cell_ctrl.flag_en = (state_reg == S_CMP);
        cell_ctrl.update  = commit && (status == ST_UPDATED);
        cell_ctrl.insert  = commit && (status == ST_INSERTED);
    end

    // The chain: each cell sees its left neighbor's entry and flag, and the
    // first cell sees the item itself with an always-smaller neighbor.
    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        logic [KEY_W-1:0]        l_key;
        logic [PORT_W-1:0]       l_port;
        logic [PAYLOAD_BITS-1:0] l_payload;
        logic                    l_lt;

        if (i == 0) begin : g_first
            assign l_key     = key_reg;
            assign l_port    = port_reg;
            assign l_payload = payload_reg;
            assign l_lt      = 1'b1;
        end else begin : g_rest
            assign l_key     = cell_key[i-1];
            assign l_port    = cell_port[i-1];
            assign l_payload = cell_payload[i-1];
            assign l_lt      = lt_vec[i-1];
        end

        skt_cell #(
            .PAYLOAD_BITS (PAYLOAD_BITS)
        ) u_cell (
            .aclk         (aclk),
            .ctrl         (cell_ctrl),
            .slot_valid   (CW'(i) < count_reg),
            .new_key      (key_reg),
            .new_port     (port_reg),
            .new_payload  (payload_reg),
            .left_key     (l_key),
            .left_port    (l_port),
            .left_payload (l_payload),
            .left_lt      (l_lt),
            .key_q        (cell_key[i]),
            .port_q       (cell_port[i]),
            .payload_q    (cell_payload[i]),
            .lt_q         (lt_vec[i]),
            .eq_q         (eq_vec[i])
        );
    end

    skt_pos_enc #(
        .ENTRIES  (ENTRIES),
        .CW       (CW)
    ) u_pos_enc (
        .lt_vec   (lt_vec),
        .eq_vec   (eq_vec),
        .position (position),
        .hit      (hit)
    );

    // A zero key reports position zero; the count grows only on an insert.
    assign pos_out = zero_key ? '0 : POS_W'(position);

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                state_next = S_COMMIT;
            end
            S_COMMIT: begin
                if (commit) begin
                    if (status == ST_INSERTED) begin
                        count_next = count_reg + CW'(1);
                    end
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {POS_W'(count_next), pos_out, status};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        if (s_tvalid && s_tready) begin
            key_reg     <= s_tdata[KEY_W-1:0];
            port_reg    <= s_tdata[KEY_W+PORT_W-1:KEY_W];
            payload_reg <= PAYLOAD_BITS'(s_tdata[KEY_W+PORT_W+IN_PAY_W-1:KEY_W+PORT_W]);
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(ENTRIES))
        else $error("fill count exceeds the table size");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        commit && status == ST_INSERTED |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow the fill count by one");

    a_other_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        commit && status != ST_INSERTED |=> count_reg == $past(count_reg))
        else $error("fill count changed without an insert");

    a_hit_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        commit && status == ST_UPDATED |-> position < count_reg)
        else $error("matching entry lies past the fill count");

    a_result_on_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> m_tvalid_reg && state_reg == S_IDLE)
        else $error("finished item gave no result");
`endif

endmodule

// ===== design/skt_cell.sv =====
// One slot of the sorted chain: entry storage, compare flags and shift logic.
module skt_cell #(
    parameter int PAYLOAD_BITS = skt_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                        aclk,
    input  skt_pkg::skt_cell_ctrl_t     ctrl,
    input  logic                        slot_valid,
    input  logic [skt_pkg::KEY_W-1:0]   new_key,
    input  logic [skt_pkg::PORT_W-1:0]  new_port,
    input  logic [PAYLOAD_BITS-1:0]     new_payload,
    input  logic [skt_pkg::KEY_W-1:0]   left_key,
    input  logic [skt_pkg::PORT_W-1:0]  left_port,
    input  logic [PAYLOAD_BITS-1:0]     left_payload,
    input  logic                        left_lt,
    output logic [skt_pkg::KEY_W-1:0]   key_q,
    output logic [skt_pkg::PORT_W-1:0]  port_q,
    output logic [PAYLOAD_BITS-1:0]     payload_q,
    output logic                        lt_q,
    output logic                        eq_q
);
    import skt_pkg::*;

    logic [KEY_W-1:0]        key_reg;
    logic [PORT_W-1:0]       port_reg;
    logic [PAYLOAD_BITS-1:0] payload_reg;
    logic                    lt_reg;
    logic                    eq_reg;
    logic                    lt_next;
    logic                    eq_next;

    // Composite key compare; slots past the fill count never count as smaller or equal.
    always_comb begin
        lt_next = slot_valid && ({key_reg, port_reg} < {new_key, new_port});
        eq_next = slot_valid && ({key_reg, port_reg} == {new_key, new_port});
    end

    always_ff @(posedge aclk) begin
        if (ctrl.flag_en) begin
            lt_reg <= lt_next;
            eq_reg <= eq_next;
        end
        if (ctrl.update && eq_reg) begin
            payload_reg <= new_payload;
        end else if (ctrl.insert && !lt_reg) begin
            if (left_lt) begin
                key_reg     <= new_key;
                port_reg    <= new_port;
                payload_reg <= new_payload;
            end else begin
                key_reg     <= left_key;
                port_reg    <= left_port;
                payload_reg <= left_payload;
            end
        end
    end

    assign key_q     = key_reg;
    assign port_q    = port_reg;
    assign payload_q = payload_reg;
    assign lt_q      = lt_reg;
    assign eq_q      = eq_reg;

endmodule

// ===== design/skt_pos_enc.sv =====
// Turns the chain's compare flags into the sorted position and a hit flag.
module skt_pos_enc #(
    parameter int ENTRIES = skt_pkg::ENTRIES_DEF,
    parameter int CW      = $clog2(ENTRIES + 1)
) (
    input  logic [ENTRIES-1:0] lt_vec,
    input  logic [ENTRIES-1:0] eq_vec,
    output logic [CW-1:0]      position,
    output logic               hit
);
    // Flags framed by an always-smaller mark below slot zero and a never-smaller
    // mark above the last slot, so every neighbor pair lies inside the vector.
    logic [ENTRIES+1:0] lt_ext;

    assign lt_ext = {1'b0, lt_vec, 1'b1};

    // The smaller-than flags form a run from slot zero, so the edge of the run
    // is a one-hot mark whose index is the position.
    always_comb begin
        position = '0;
        for (int i = 0; i <= ENTRIES; i++) begin
            if (lt_ext[i] && !lt_ext[i+1]) begin
                position = position | CW'(i);
            end
        end
        hit = |eq_vec;
    end

endmodule

// ===== tb/sv/sorted_key_table_upsert_test.sv =====
// Self-checking testbench of the sorted key table with insert-or-update.
module sorted_key_table_upsert_test;
    import skt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY     = ENTRIES_DEF;
    localparam int RANDOM_ITEMS = 1350;

    // One offered entry, laid out exactly as s_tdata: key_id in the lowest bits.
    typedef struct packed {
        logic [IN_PAY_W-1:0] payload;
        logic [PORT_W-1:0]   port;
        logic [KEY_W-1:0]    key;
    } offer_t;

    // One result, laid out exactly as m_tdata: status in the lowest bits.
    typedef struct packed {
        logic [POS_W-1:0] entry_count;
        logic [POS_W-1:0] position;
        skt_status_t      status;
    } upsert_result_t;

    // Patterns that the result side cycles through when it stalls.
    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_PERIODIC,
        RDY_SPARSE
    } ready_pattern_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;

    sorted_key_table_upsert dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Items waiting to be offered, and results waiting to come back.
    offer_t         pending_offers[$];
    upsert_result_t expected_results[$];
    int unsigned    mismatches = 0;

    // The generator's view of which keys sit in the table, packed as {key, port}.
    // It lets the stimulus aim updates at keys that are really present.
    logic [KEY_W+PORT_W-1:0] stored_keys[$];

    // The predictor's own copy of the table. The payload never shows up in a
    // result, so only the composite keys and the fill count are tracked.
    logic [KEY_W-1:0]  tbl_key  [CAPACITY];
    logic [PORT_W-1:0] tbl_port [CAPACITY];
    int unsigned       tbl_count = 0;

    // Applies one offer to the predicted table and returns the result it causes.
    function automatic upsert_result_t predict_upsert(input logic [KEY_W-1:0] key,
                                                      input logic [PORT_W-1:0] port);
        upsert_result_t res;
        int unsigned    pos;
        pos = 0;
        if (key == '0) begin
            // A zero identifier leaves the table alone and reports position zero.
            res.status = ST_ZERO_KEY;
        end else begin
            // The table is sorted, so the number of smaller keys is the lower bound.
            for (int unsigned i = 0; i < tbl_count; i++) begin
                if (tbl_key[i] < key || (tbl_key[i] == key && tbl_port[i] < port)) begin
                    pos++;
                end
            end
            if (pos < tbl_count && tbl_key[pos] == key && tbl_port[pos] == port) begin
                // Present keys are updated even when the table is full.
                res.status = ST_UPDATED;
            end else if (tbl_count >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                for (int unsigned i = tbl_count; i > pos; i--) begin
                    tbl_key[i]  = tbl_key[i-1];
                    tbl_port[i] = tbl_port[i-1];
                end
                tbl_key[pos]  = key;
                tbl_port[pos] = port;
                tbl_count++;
                res.status = ST_INSERTED;
            end
        end
        res.position    = pos[POS_W-1:0];
        res.entry_count = tbl_count[POS_W-1:0];
        return res;
    endfunction

    function automatic bit key_is_stored(input logic [KEY_W+PORT_W-1:0] kp);
        foreach (stored_keys[i]) begin
            if (stored_keys[i] == kp) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Queues one offer and keeps the generator's key list in step with the table.
    task automatic queue_offer(input logic [KEY_W-1:0] key, input logic [PORT_W-1:0] port,
                               input logic [IN_PAY_W-1:0] payload);
        offer_t o;
        o.key     = key;
        o.port    = port;
        o.payload = payload;
        pending_offers.push_back(o);
        if (key != '0 && stored_keys.size() < CAPACITY && !key_is_stored({key, port})) begin
            stored_keys.push_back({key, port});
        end
    endtask

    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s", msg);
        end
    endtask

    function automatic logic [KEY_W-1:0] random_key_id();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [PORT_W-1:0] random_port();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return PORT_W'($urandom);
        endcase
    endfunction

    // Sender: bursts of back-to-back items separated by random gaps. A gap of
    // zero is common, so long stretches run with no idling at all.
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;

    always @(posedge aclk) begin
        offer_t cur;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                cur = s_tdata;
                expected_results.push_back(predict_upsert(cur.key, cur.port));
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_offers.size() > 0) begin
                    s_tdata  <= pending_offers.pop_front();
                    s_tvalid <= 1'b1;
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks every accepted result against the oldest prediction and
    // switches to a randomly chosen stall pattern whenever the current one runs out.
    ready_pattern_t ready_pattern = RDY_ALWAYS;
    int unsigned    pattern_left  = 0;
    int unsigned    rx_cycle      = 0;

    always @(posedge aclk) begin
        upsert_result_t want;
        upsert_result_t got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_results.size() == 0) begin
                    note_failure($sformatf("result %h arrived with no item outstanding",
                                           m_tdata));
                end else begin
                    want = expected_results.pop_front();
                    if (got.status != want.status) begin
                        note_failure($sformatf("status: expected %0d, got %0d",
                                               want.status, got.status));
                    end
                    if (got.position != want.position) begin
                        note_failure($sformatf("position: expected %0d, got %0d",
                                               want.position, got.position));
                    end
                    if (got.entry_count != want.entry_count) begin
                        note_failure($sformatf("entry_count: expected %0d, got %0d",
                                               want.entry_count, got.entry_count));
                    end
                end
            end
            if (pattern_left == 0) begin
                ready_pattern = ready_pattern_t'($urandom_range(0, 3));
                pattern_left  = $urandom_range(20, 120);
            end else begin
                pattern_left--;
            end
            rx_cycle++;
            case (ready_pattern)
                RDY_ALWAYS:   m_tready <= 1'b1;
                RDY_COIN:     m_tready <= 1'($urandom_range(0, 1));
                RDY_PERIODIC: m_tready <= (rx_cycle % 5) != 4;
                default:      m_tready <= ($urandom_range(0, 15) == 0);
            endcase
        end
    end

    // Stimulus, reset and the end of the run.
    initial begin
        logic [KEY_W+PORT_W-1:0] pick;
        logic [KEY_W-1:0]        id;
        int unsigned             choice;

        // Directed part: zero keys on an empty table, the extreme identifiers
        // and ports, ordering by port within one identifier, and updates.
        queue_offer('0, '0, '0);
        queue_offer('0, '1, '1);
        queue_offer('1, '1, '1);
        queue_offer(64'd1, '0, 32'h0000_0001);
        queue_offer(64'd1, '0, 32'hDEAD_BEEF);
        queue_offer(64'd1, '1, 32'h1234_5678);
        queue_offer(64'd1, 16'd1, '0);
        queue_offer('1, '0, 32'h8000_0000);
        queue_offer('1, '1, '0);
        queue_offer(64'h8000_0000_0000_0000, 16'h8000, 32'h5555_5555);
        queue_offer(64'h7FFF_FFFF_FFFF_FFFF, 16'h7FFF, 32'hAAAA_AAAA);
        queue_offer('0, 16'h1234, 32'h0F0F_0F0F);
        queue_offer(64'h5555_5555_5555_5555, 16'h5555, '1);
        queue_offer(64'hAAAA_AAAA_AAAA_AAAA, 16'hAAAA, '0);
        queue_offer(64'h8000_0000_0000_0000, 16'h7FFF, 32'h0000_FFFF);
        queue_offer(64'h8000_0000_0000_0000, 16'h8000, 32'hFFFF_0000);
        queue_offer(64'd2, '0, 32'h0000_0002);
        queue_offer(64'd1, '1, '1);

        // Random part. While the table fills, new keys and updates mix; once
        // it is full, new keys are refused and updates to stored keys go on.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            choice = $urandom_range(0, 99);
            if (choice < 8) begin
                queue_offer('0, random_port(), $urandom);
            end else if (choice < 50 && stored_keys.size() > 0) begin
                pick = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
                queue_offer(pick[KEY_W+PORT_W-1:PORT_W], pick[PORT_W-1:0], $urandom);
            end else begin
                pick = (stored_keys.size() > 0) ?
                       stored_keys[$urandom_range(0, stored_keys.size() - 1)] : '0;
                id = pick[KEY_W+PORT_W-1:PORT_W];
                case ($urandom_range(0, 4))
                    0:       id = id;                    // same identifier, other port
                    1:       id = id + 64'd1;            // neighbor above
                    2:       id = id - 64'd1;            // neighbor below
                    3:       id = $urandom_range(0, 1) ? '1 : 64'd1;
                    default: id = random_key_id();
                endcase
                if (id == '0) begin
                    id = 64'd1;
                end
                queue_offer(id, random_port(), $urandom);
            end
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_offers.size() != 0 || s_tvalid) begin
            @(posedge aclk);
        end
        while (expected_results.size() != 0) begin
            @(posedge aclk);
        end
        // Wait on so that a stray extra result would still be seen.
        repeat (20) @(posedge aclk);

        if (mismatches == 0) begin
            $display("sorted_key_table_upsert test passed");
        end else begin
            $display("sorted_key_table_upsert test failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5ms;
        $display("sorted_key_table_upsert test failed");
        $finish;
    end

endmodule
